### hw/rtl/johnson_cook_flow_stress_macros.svh
// Assertion helpers for the RTL file that checks its own logic.
`ifndef JOHNSON_COOK_FLOW_STRESS_MACROS_SVH
`define JOHNSON_COOK_FLOW_STRESS_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define JCFS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define JCFS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/jcfs_pkg.sv
package jcfs_pkg;

   localparam int DEFAULT_TABLE_ENTRIES = 256;

   localparam int LOG_W = 22;   // log2 in Q16, input up to 32 bits
   localparam int Y_W   = 27;   // signed exponent argument in Q16
   localparam int EXP_W = 63;   // exp2 result in Q30

   localparam int ONE_Q16     = 65536;
   localparam int LN2_Q16     = 45426;
   localparam int STRAIN_BIAS = 20 * 65536;  // Q4.20 strain: subtract 20 from log2
   localparam int EXP_LIMIT   = 40 * 65536;
   localparam int EXP_BIAS    = 64 * 65536;
   localparam int N_FRAC_BITS = 14;
   localparam int M_FRAC_BITS = 13;

   localparam logic [63:0] Q30 = 64'd1073741824;

   localparam logic [23:0] RST_YIELD_A   = 24'd0;
   localparam logic [23:0] RST_HARD_B    = 24'd0;
   localparam logic [15:0] RST_RATE_C    = 16'd0;
   localparam logic [15:0] RST_EXP_N     = 16'd16384;
   localparam logic [15:0] RST_EXP_M     = 16'd8192;
   localparam logic [15:0] RST_TREF      = 16'd4720;
   localparam logic [15:0] RST_TMELT     = 16'd28000;
   localparam logic [31:0] RST_RATE_REF  = 32'd256;

   typedef enum logic [3:0] {
      REG_YIELD_A  = 4'd0,
      REG_HARD_B   = 4'd1,
      REG_RATE_C   = 4'd2,
      REG_EXP_N    = 4'd3,
      REG_EXP_M    = 4'd4,
      REG_TREF     = 4'd5,
      REG_TMELT    = 4'd6,
      REG_RATE_REF = 4'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      REGION_COLD = 2'd0,
      REGION_SOFT = 2'd1,
      REGION_MELT = 2'd2
   } region_type;

   typedef struct packed {
      region_type region;
      logic       zero_strain;
      logic       temp_eq;
      logic       rate_gt;
   } side_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bit_v;
      logic [63:0] rem;
      res   = '0;
      bit_v = 64'h4000_0000_0000_0000;
      rem   = v;
      for (int k = 0; k < 32; k++) begin
         if (rem >= res + bit_v) begin
            rem = rem - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // Repeated square roots of two, root k is 2^(2^-k) in Q30.
   function automatic logic [16:0][63:0] calc_roots();
      logic [16:0][63:0] r;
      r[0] = Q30 << 1;
      for (int k = 1; k <= 16; k++) begin
         r[k] = isqrt64(r[k-1] << 30);
      end
      return r;
   endfunction

   localparam logic [16:0][63:0] ROOTS = calc_roots();

   // log2(1 + xoff / 2^30) in Q16 by repeated squaring.
   function automatic logic [16:0] log_entry(input logic [63:0] xoff);
      logic [63:0] x;
      logic [16:0] res;
      x   = Q30 + xoff;
      res = '0;
      for (int k = 1; k <= 16; k++) begin
         x = (x * x) >> 30;
         if (x >= (Q30 << 1)) begin
            x = x >> 1;
            res[16-k] = 1'b1;
         end
      end
      return res;
   endfunction

   // 2^(f / 2^16) in Q30 from the root products.
   function automatic logic [31:0] exp_entry(input logic [15:0] f);
      logic [63:0] r;
      r = Q30;
      for (int k = 1; k <= 16; k++) begin
         if (f[16-k]) begin
            r = (r * ROOTS[k]) >> 30;
         end
      end
      return r[31:0];
   endfunction

endpackage

### hw/rtl/johnson_cook_flow_stress.sv
// Throughput: one item per cycle; all stages advance together, gated by a
// two-entry result buffer, so req_stall rises only when that buffer is full.
// Reset (synchronous, active high) empties the pipeline and the result buffer
// and returns every configuration register to its default value.
`include "johnson_cook_flow_stress_macros.svh"

module johnson_cook_flow_stress #(
   parameter int APPROX_TABLE_ENTRIES = jcfs_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [23:0] req_plastic_strain,
   input  logic [31:0] req_strain_rate,
   input  logic [15:0] req_temperature,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_flow_stress,
   output logic [1:0]  rsp_thermal_region,
   output logic        rsp_saturated,
   input  logic        csr_we,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int DEPTH = 12;
   localparam int LW    = jcfs_pkg::LOG_W;
   localparam int EW    = jcfs_pkg::EXP_W;

   typedef struct packed {
      logic [31:0]          flow_stress;
      jcfs_pkg::region_type region;
      logic                 saturated;
   } rsp_entry_type;

   // Configuration registers.
   logic [23:0] yield_a_ff;
   logic [23:0] hard_b_ff;
   logic [15:0] rate_c_ff;
   logic [15:0] exp_n_ff;
   logic [15:0] exp_m_ff;
   logic [15:0] tref_ff;
   logic [15:0] tmelt_ff;
   logic [31:0] rate_ref_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         yield_a_ff  <= jcfs_pkg::RST_YIELD_A;
         hard_b_ff   <= jcfs_pkg::RST_HARD_B;
         rate_c_ff   <= jcfs_pkg::RST_RATE_C;
         exp_n_ff    <= jcfs_pkg::RST_EXP_N;
         exp_m_ff    <= jcfs_pkg::RST_EXP_M;
         tref_ff     <= jcfs_pkg::RST_TREF;
         tmelt_ff    <= jcfs_pkg::RST_TMELT;
         rate_ref_ff <= jcfs_pkg::RST_RATE_REF;
      end else if (csr_we) begin
         unique case (csr_index)
            jcfs_pkg::REG_YIELD_A:  yield_a_ff  <= csr_wdata[23:0];
            jcfs_pkg::REG_HARD_B:   hard_b_ff   <= csr_wdata[23:0];
            jcfs_pkg::REG_RATE_C:   rate_c_ff   <= csr_wdata[15:0];
            jcfs_pkg::REG_EXP_N:    exp_n_ff    <= csr_wdata[15:0];
            jcfs_pkg::REG_EXP_M:    exp_m_ff    <= csr_wdata[15:0];
            jcfs_pkg::REG_TREF:     tref_ff     <= csr_wdata[15:0];
            jcfs_pkg::REG_TMELT:    tmelt_ff    <= csr_wdata[15:0];
            jcfs_pkg::REG_RATE_REF: rate_ref_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Flow control: the whole pipeline moves while the result buffer has room.
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       en;
   logic       accept;
   logic       push;
   logic       pop;

   assign en        = (cnt_ff != 2'd2);
   assign req_stall = !en;
   assign accept    = req_valid && en;

   logic [DEPTH:1]     vld_ff;
   jcfs_pkg::side_type side_ff [1:DEPTH];
   jcfs_pkg::side_type side_in;

   // Stage 1: input capture and temperature/rate classification.
   logic [31:0] rate_ref_eff;
   logic [23:0] strain_ff;
   logic [31:0] rate_ff;
   logic [31:0] rref_ff;
   logic [15:0] dt_ff;
   logic [15:0] dm_ff;

   always_comb begin
      rate_ref_eff        = (rate_ref_ff == 32'd0) ? 32'd1 : rate_ref_ff;
      side_in.zero_strain = (req_plastic_strain == 24'd0);
      side_in.temp_eq     = (req_temperature == tref_ff);
      side_in.rate_gt     = (req_strain_rate > rate_ref_eff);
      if (req_temperature < tref_ff) begin
         side_in.region = jcfs_pkg::REGION_COLD;
      end else if (req_temperature >= tmelt_ff) begin
         side_in.region = jcfs_pkg::REGION_MELT;
      end else begin
         side_in.region = jcfs_pkg::REGION_SOFT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-1:1], accept};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[1] <= side_in;
         for (int s = 2; s <= DEPTH; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         strain_ff <= req_plastic_strain;
         rate_ff   <= req_strain_rate;
         rref_ff   <= rate_ref_eff;
         dt_ff     <= req_temperature - tref_ff;
         dm_ff     <= tmelt_ff - tref_ff;
      end
   end

   // Stages 2 to 4: logarithms.
   logic [LW-1:0] log_strain;
   logic [LW-1:0] log_rate;
   logic [LW-1:0] log_rref;
   logic [LW-1:0] log_dt;
   logic [LW-1:0] log_dm;

   jcfs_log2 #(.APPROX_TABLE_ENTRIES(APPROX_TABLE_ENTRIES)) u_log_strain (
      .clock(clock), .enable(en), .value({8'd0, strain_ff}), .log_q16(log_strain)
   );
   jcfs_log2 #(.APPROX_TABLE_ENTRIES(APPROX_TABLE_ENTRIES)) u_log_rate (
      .clock(clock), .enable(en), .value(rate_ff), .log_q16(log_rate)
   );
   jcfs_log2 #(.APPROX_TABLE_ENTRIES(APPROX_TABLE_ENTRIES)) u_log_rref (
      .clock(clock), .enable(en), .value(rref_ff), .log_q16(log_rref)
   );
   jcfs_log2 #(.APPROX_TABLE_ENTRIES(APPROX_TABLE_ENTRIES)) u_log_dt (
      .clock(clock), .enable(en), .value({16'd0, dt_ff}), .log_q16(log_dt)
   );
   jcfs_log2 #(.APPROX_TABLE_ENTRIES(APPROX_TABLE_ENTRIES)) u_log_dm (
      .clock(clock), .enable(en), .value({16'd0, dm_ff}), .log_q16(log_dm)
   );

   // Stages 5 to 9: strain power and homologous temperature power.
   logic [EW-1:0] pw_strain;
   logic [EW-1:0] pw_temp;

   jcfs_pow #(
      .APPROX_TABLE_ENTRIES(APPROX_TABLE_ENTRIES),
      .FRAC_BITS(jcfs_pkg::N_FRAC_BITS)
   ) u_pow_strain (
      .clock(clock), .enable(en), .log_a(log_strain),
      .log_b(LW'(jcfs_pkg::STRAIN_BIAS)), .exponent(exp_n_ff), .power_q30(pw_strain)
   );

   jcfs_pow #(
      .APPROX_TABLE_ENTRIES(APPROX_TABLE_ENTRIES),
      .FRAC_BITS(jcfs_pkg::M_FRAC_BITS)
   ) u_pow_temp (
      .clock(clock), .enable(en), .log_a(log_dt),
      .log_b(log_dm), .exponent(exp_m_ff), .power_q30(pw_temp)
   );

   // Stages 5 to 10: rate factor. The log is monotonic, so the difference
   // is never negative when the rate exceeds the reference.
   logic [21:0] d_ff;
   logic [21:0] ln_ff;
   logic [21:0] cl_ff;
   logic [22:0] rf8_in;
   logic [22:0] rf8_ff;
   logic [22:0] rf9_ff;
   logic [22:0] rf10_ff;

   assign rf8_in = side_ff[7].rate_gt ? 23'(jcfs_pkg::ONE_Q16) + 23'(cl_ff)
                                      : 23'(jcfs_pkg::ONE_Q16);

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= log_rate - log_rref;
         ln_ff   <= 22'((38'(d_ff) * 38'(jcfs_pkg::LN2_Q16)) >> 16);
         cl_ff   <= 22'((38'(rate_c_ff) * 38'(ln_ff)) >> 16);
         rf8_ff  <= rf8_in;
         rf9_ff  <= rf8_ff;
         rf10_ff <= rf9_ff;
      end
   end

   // Stage 10: special cases, hardening products and thermal factor.
   // A Q4.20 strain limits strain^n below 2^46 in Q30.
   logic [EW-1:0] pw_sel;
   logic [EW-1:0] xm_sel;
   logic [EW-1:0] xm_sh;
   logic [16:0]   xm_clip;
   logic [16:0]   th_in;
   logic [16:0]   th_ff;
   logic [40:0]   prod_hi_ff;
   logic [23:0]   prod_lo_ff;

   always_comb begin
      if (side_ff[9].zero_strain) begin
         pw_sel = (exp_n_ff == 16'd0) ? EW'(jcfs_pkg::Q30) : '0;
      end else begin
         pw_sel = pw_strain;
      end
      if (side_ff[9].temp_eq) begin
         xm_sel = (exp_m_ff == 16'd0) ? EW'(jcfs_pkg::Q30) : '0;
      end else begin
         xm_sel = pw_temp;
      end
      xm_sh   = xm_sel >> 14;
      xm_clip = (xm_sh > EW'(jcfs_pkg::ONE_Q16)) ? 17'(jcfs_pkg::ONE_Q16) : xm_sh[16:0];
      unique case (side_ff[9].region)
         jcfs_pkg::REGION_COLD: th_in = 17'(jcfs_pkg::ONE_Q16);
         jcfs_pkg::REGION_MELT: th_in = 17'd0;
         default:               th_in = 17'(jcfs_pkg::ONE_Q16) - xm_clip;
      endcase
   end

   // Stages 11 to 12: hardening term, combined factor, final product.
   logic [41:0] hard_ff;
   logic [23:0] g_ff;
   logic [49:0] phi_ff;
   logic [23:0] plo_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_hi_ff <= 41'(hard_b_ff) * 41'(pw_sel[46:30]);
         prod_lo_ff <= 24'((54'(hard_b_ff) * 54'(pw_sel[29:0])) >> 30);
         th_ff      <= th_in;
         hard_ff    <= 42'(yield_a_ff) + 42'(prod_hi_ff) + 42'(prod_lo_ff);
         g_ff       <= 24'((40'(rf10_ff) * 40'(th_ff)) >> 16);
         phi_ff     <= 50'(hard_ff[41:16]) * 50'(g_ff);
         plo_ff     <= 24'((40'(hard_ff[15:0]) * 40'(g_ff)) >> 16);
      end
   end

   // Stage 13: sum, saturate and write into the result buffer.
   logic [50:0]   sum;
   rsp_entry_type entry;

   always_comb begin
      sum               = 51'(phi_ff) + 51'(plo_ff);
      entry.saturated   = |sum[50:32];
      entry.flow_stress = entry.saturated ? 32'hFFFF_FFFF : sum[31:0];
      entry.region      = side_ff[DEPTH].region;
   end

   rsp_entry_type fifo_ff [2];
   logic          wr_ptr_ff;
   logic          rd_ptr_ff;

   assign push   = en && vld_ff[DEPTH];
   assign pop    = rsp_valid && !rsp_stall;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= entry;
      end
   end

   assign rsp_valid          = (cnt_ff != 2'd0);
   assign rsp_flow_stress    = fifo_ff[rd_ptr_ff].flow_stress;
   assign rsp_thermal_region = fifo_ff[rd_ptr_ff].region;
   assign rsp_saturated      = fifo_ff[rd_ptr_ff].saturated;

   `JCFS_ASSERT_NXT(a_accept_enters, clock, reset, accept, vld_ff[1], "transfer did not enter pipeline")
   `JCFS_ASSERT_NXT(a_stall_holds, clock, reset, !en, $stable(vld_ff), "pipeline moved while stalled")
   `JCFS_ASSERT_IMP(a_sat_max, clock, reset, rsp_valid && rsp_saturated, rsp_flow_stress == 32'hFFFF_FFFF, "saturated result not at maximum")
   `JCFS_ASSERT_IMP(a_melt_zero, clock, reset, rsp_valid && (rsp_thermal_region == jcfs_pkg::REGION_MELT), (rsp_flow_stress == 32'd0) && !rsp_saturated, "melted point has stress")

endmodule

### hw/rtl/jcfs_log2.sv
module jcfs_log2 #(
   parameter int APPROX_TABLE_ENTRIES = jcfs_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [31:0]                value,
   output logic [jcfs_pkg::LOG_W-1:0] log_q16
);

   localparam int IDX_W = $clog2(APPROX_TABLE_ENTRIES);
   localparam int TAB_W = $clog2(APPROX_TABLE_ENTRIES + 1);
   localparam int T_W   = 30 + TAB_W;

   logic [16:0] lt [APPROX_TABLE_ENTRIES+1];

   for (genvar gi = 0; gi <= APPROX_TABLE_ENTRIES; gi++) begin : g_tab
      localparam logic [63:0] XOFF = (64'(gi) << 30) / APPROX_TABLE_ENTRIES;
      if (gi == APPROX_TABLE_ENTRIES) begin : g_last
         assign lt[gi] = 17'd65536;
      end else begin : g_mid
         assign lt[gi] = jcfs_pkg::log_entry(XOFF);
      end
   end

   logic [4:0]              pos_in;
   logic [4:0]              pos1_ff;
   logic [4:0]              pos2_ff;
   logic [31:0]             norm;
   logic [29:0]             frac_in;
   logic [29:0]             frac_ff;
   logic [T_W-1:0]          t_prod;
   logic [IDX_W-1:0]        idx_in;
   logic [IDX_W-1:0]        idx_ff;
   logic [29:0]             rem_in;
   logic [29:0]             rem_ff;
   logic [16:0]             base;
   logic [16:0]             nxt;
   logic [46:0]             interp;
   logic [jcfs_pkg::LOG_W-1:0] log_in;
   logic [jcfs_pkg::LOG_W-1:0] log_ff;

   // Leading-one position and the 30 fraction bits below it.
   always_comb begin
      pos_in = '0;
      for (int b = 1; b < 32; b++) begin
         if (value[b]) begin
            pos_in = 5'(b);
         end
      end
      norm    = value << (5'd31 - pos_in);
      frac_in = norm[30:1];
   end

   assign t_prod = T_W'(frac_ff) * T_W'(APPROX_TABLE_ENTRIES);
   assign idx_in = t_prod[30 +: IDX_W];
   assign rem_in = t_prod[29:0];

   always_comb begin
      base   = lt[TAB_W'(idx_ff)];
      nxt    = lt[TAB_W'(idx_ff) + TAB_W'(1)];
      interp = 47'(nxt - base) * 47'(rem_ff);
      log_in = jcfs_pkg::LOG_W'({pos2_ff, 16'd0}) + jcfs_pkg::LOG_W'(base)
             + jcfs_pkg::LOG_W'(interp >> 30);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pos1_ff <= pos_in;
         frac_ff <= frac_in;
         pos2_ff <= pos1_ff;
         idx_ff  <= idx_in;
         rem_ff  <= rem_in;
         log_ff  <= log_in;
      end
   end

   assign log_q16 = log_ff;

endmodule

### hw/rtl/jcfs_pow.sv
module jcfs_pow #(
   parameter int APPROX_TABLE_ENTRIES = jcfs_pkg::DEFAULT_TABLE_ENTRIES,
   parameter int FRAC_BITS            = jcfs_pkg::N_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [jcfs_pkg::LOG_W-1:0] log_a,
   input  logic [jcfs_pkg::LOG_W-1:0] log_b,
   input  logic [15:0]                exponent,
   output logic [jcfs_pkg::EXP_W-1:0] power_q30
);

   localparam int LW    = jcfs_pkg::LOG_W;
   localparam int YW    = jcfs_pkg::Y_W;
   localparam int EW    = jcfs_pkg::EXP_W;
   localparam int IDX_W = $clog2(APPROX_TABLE_ENTRIES);
   localparam int TAB_W = $clog2(APPROX_TABLE_ENTRIES + 1);
   localparam int T_W   = 16 + TAB_W;

   logic [31:0] et [APPROX_TABLE_ENTRIES+1];

   for (genvar gi = 0; gi <= APPROX_TABLE_ENTRIES; gi++) begin : g_tab
      localparam logic [63:0] FOFF = (64'(gi) << 16) / APPROX_TABLE_ENTRIES;
      if (gi == APPROX_TABLE_ENTRIES) begin : g_last
         assign et[gi] = 32'h8000_0000;
      end else begin : g_mid
         assign et[gi] = jcfs_pkg::exp_entry(FOFF[15:0]);
      end
   end

   logic [LW:0]            diff_in;
   logic                   neg_in;
   logic                   neg_ff;
   logic [LW-1:0]          mag_in;
   logic [LW-1:0]          mag_ff;
   logic [37:0]            prod;
   logic [37:0]            prod_sh;
   logic signed [YW-1:0]   y_in;
   logic signed [YW-1:0]   y_ff;
   logic signed [YW-1:0]   y_clamp;
   logic signed [YW-1:0]   y_bias;
   logic [22:0]            yb;
   logic signed [7:0]      ip_in;
   logic signed [7:0]      ip1_ff;
   logic signed [7:0]      ip2_ff;
   logic [T_W-1:0]         t_prod;
   logic [IDX_W-1:0]       idx_ff;
   logic [15:0]            rem_ff;
   logic [31:0]            base;
   logic [31:0]            nxt;
   logic [47:0]            interp;
   logic [31:0]            m_in;
   logic [31:0]            m_ff;
   logic [4:0]             up_amt;
   logic [7:0]             dn_amt;
   logic [EW-1:0]          pow_in;
   logic [EW-1:0]          pow_ff;

   // Difference of logs as sign and magnitude.
   always_comb begin
      diff_in = {1'b0, log_a} - {1'b0, log_b};
      neg_in  = diff_in[LW];
      mag_in  = neg_in ? LW'(-diff_in) : diff_in[LW-1:0];
   end

   // Scale by the exponent, truncating toward zero.
   always_comb begin
      prod    = 38'(mag_ff) * 38'(exponent);
      prod_sh = prod >> FRAC_BITS;
      y_in    = neg_ff ? -YW'(prod_sh) : YW'(prod_sh);
   end

   always_comb begin
      if (y_ff > YW'(jcfs_pkg::EXP_LIMIT)) begin
         y_clamp = YW'(jcfs_pkg::EXP_LIMIT);
      end else if (y_ff < -YW'(jcfs_pkg::EXP_LIMIT)) begin
         y_clamp = -YW'(jcfs_pkg::EXP_LIMIT);
      end else begin
         y_clamp = y_ff;
      end
      y_bias = y_clamp + YW'(jcfs_pkg::EXP_BIAS);
      yb     = y_bias[22:0];
      ip_in  = $signed({1'b0, yb[22:16]}) - 8'sd64;
      t_prod = T_W'(yb[15:0]) * T_W'(APPROX_TABLE_ENTRIES);
   end

   always_comb begin
      base   = et[TAB_W'(idx_ff)];
      nxt    = et[TAB_W'(idx_ff) + TAB_W'(1)];
      interp = 48'(nxt - base) * 48'(rem_ff);
      m_in   = base + 32'(interp >> 16);
   end

   always_comb begin
      up_amt = (ip2_ff > 8'sd31) ? 5'd31 : ip2_ff[4:0];
      dn_amt = 8'(-ip2_ff);
      if (ip2_ff >= 8'sd0) begin
         pow_in = EW'(m_ff) << up_amt;
      end else begin
         pow_in = EW'(m_ff >> dn_amt);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
         y_ff   <= y_in;
         ip1_ff <= ip_in;
         idx_ff <= t_prod[16 +: IDX_W];
         rem_ff <= t_prod[15:0];
         ip2_ff <= ip1_ff;
         m_ff   <= m_in;
         pow_ff <= pow_in;
      end
   end

   assign power_q30 = pow_ff;

endmodule

### tb/testbench.sv
module testbench;

   localparam int  TABLE_SIZE = 256;
   localparam longint unsigned ONE_Q30 = 64'd1073741824;
   localparam int  STALL_LIMIT = 2000;

   typedef struct {
      logic [31:0]          flow_stress;
      jcfs_pkg::region_type region;
      logic                 saturated;
   } stress_result_type;

   // Predicts the flow stress of each transferred material point and holds the
   // predictions until the matching result comes out of the block.
   class stress_scoreboard;
      longint unsigned   log_tab[TABLE_SIZE + 1];
      longint unsigned   exp_tab[TABLE_SIZE + 1];
      longint unsigned   coef[8];
      stress_result_type pending_results[$];
      int                errors;
      int                checked;
      int                region_seen[3];
      int                saturations;

      function new();
         longint unsigned roots[17];
         longint unsigned x, r, f;
         longint unsigned res;
         errors = 0;
         checked = 0;
         saturations = 0;
         foreach (region_seen[i]) region_seen[i] = 0;
         roots[0] = 2 * ONE_Q30;
         for (int k = 1; k <= 16; k++) roots[k] = int_sqrt(roots[k - 1] << 30);
         for (int i = 0; i < TABLE_SIZE; i++) begin
            x = ONE_Q30 + ((longint'(i) << 30) / TABLE_SIZE);
            f = (longint'(i) << 16) / TABLE_SIZE;
            r = ONE_Q30;
            res = 0;
            for (int k = 1; k <= 16; k++) begin
               x = (x * x) >> 30;
               if (x >= 2 * ONE_Q30) begin
                  x = x >> 1;
                  res = res | (64'd1 << (16 - k));
               end
               if ((f >> (16 - k)) & 1) r = (r * roots[k]) >> 30;
            end
            log_tab[i] = res;
            exp_tab[i] = r;
         end
         log_tab[TABLE_SIZE] = 65536;
         exp_tab[TABLE_SIZE] = 2 * ONE_Q30;
         reset_coefs();
      endfunction

      function void reset_coefs();
         coef[jcfs_pkg::REG_YIELD_A]  = jcfs_pkg::RST_YIELD_A;
         coef[jcfs_pkg::REG_HARD_B]   = jcfs_pkg::RST_HARD_B;
         coef[jcfs_pkg::REG_RATE_C]   = jcfs_pkg::RST_RATE_C;
         coef[jcfs_pkg::REG_EXP_N]    = jcfs_pkg::RST_EXP_N;
         coef[jcfs_pkg::REG_EXP_M]    = jcfs_pkg::RST_EXP_M;
         coef[jcfs_pkg::REG_TREF]     = jcfs_pkg::RST_TREF;
         coef[jcfs_pkg::REG_TMELT]    = jcfs_pkg::RST_TMELT;
         coef[jcfs_pkg::REG_RATE_REF] = jcfs_pkg::RST_RATE_REF;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res, bit_v;
         res = 0;
         bit_v = 64'd1 << 62;
         while (bit_v > v) bit_v = bit_v >> 2;
         while (bit_v != 0) begin
            if (v >= res + bit_v) begin
               v = v - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
         return res;
      endfunction

      function void write_coef(logic [3:0] index, logic [31:0] data);
         case (index) inside
            jcfs_pkg::REG_YIELD_A, jcfs_pkg::REG_HARD_B: coef[index] = data[23:0];
            jcfs_pkg::REG_RATE_C, jcfs_pkg::REG_EXP_N, jcfs_pkg::REG_EXP_M,
            jcfs_pkg::REG_TREF, jcfs_pkg::REG_TMELT:
               coef[index] = data[15:0];
            jcfs_pkg::REG_RATE_REF: coef[index] = data;
            default: ;
         endcase
      endfunction

      // Base-2 logarithm of a nonzero raw value, Q16.
      function longint log2_q16(longint unsigned v);
         int p;
         longint unsigned mant, t, idx, rem;
         p = 63;
         while (p > 0 && ((v >> p) & 1) == 0) p--;
         mant = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
         t = (mant - ONE_Q30) * TABLE_SIZE;
         idx = t >> 30;
         if (idx >= TABLE_SIZE) idx = TABLE_SIZE - 1;
         rem = t & (ONE_Q30 - 1);
         return longint'(p) * 65536 +
            longint'(log_tab[idx] + (((log_tab[idx + 1] - log_tab[idx]) * rem) >> 30));
      endfunction

      function longint scaled_product(longint a, longint unsigned b, int s);
         if (a >= 0) return longint'((unsigned'(a) * b) >> s);
         return -longint'((unsigned'(-a) * b) >> s);
      endfunction

      // Power of two for a Q16 exponent, Q30 result.
      function longint unsigned exp2_q30(longint y);
         longint lim, ip;
         longint unsigned yb, fr, t, idx, rem, m;
         lim = 40 * 65536;
         if (y > lim) y = lim;
         if (y < -lim) y = -lim;
         yb = unsigned'(y + 64 * 65536);
         ip = longint'(yb >> 16) - 64;
         fr = yb & 16'hFFFF;
         t = fr * TABLE_SIZE;
         idx = t >> 16;
         rem = t & 16'hFFFF;
         m = exp_tab[idx] + (((exp_tab[idx + 1] - exp_tab[idx]) * rem) >> 16);
         if (ip > 31) ip = 31;
         if (ip >= 0) return m << ip;
         return m >> (-ip);
      endfunction

      function void note_input(logic [23:0] strain, logic [31:0] rate, logic [15:0] temp);
         longint unsigned   ref_rate, pw, hard, rf, th, g, stress, xm, d, ln;
         longint unsigned   tref, tmelt;
         stress_result_type exp_res;
         ref_rate = (coef[jcfs_pkg::REG_RATE_REF] != 0) ? coef[jcfs_pkg::REG_RATE_REF] : 1;
         tref = coef[jcfs_pkg::REG_TREF];
         tmelt = coef[jcfs_pkg::REG_TMELT];

         if (strain == 0) pw = (coef[jcfs_pkg::REG_EXP_N] != 0) ? 0 : ONE_Q30;
         else pw = exp2_q30(scaled_product(log2_q16(strain) - 20 * 65536,
                                           coef[jcfs_pkg::REG_EXP_N], 14));
         hard = coef[jcfs_pkg::REG_YIELD_A] + coef[jcfs_pkg::REG_HARD_B] * (pw >> 30) +
                ((coef[jcfs_pkg::REG_HARD_B] * (pw & (ONE_Q30 - 1))) >> 30);

         rf = 65536;
         if (rate > ref_rate) begin
            d = unsigned'(log2_q16(rate) - log2_q16(ref_rate));
            ln = (d * 45426) >> 16;
            rf = rf + ((coef[jcfs_pkg::REG_RATE_C] * ln) >> 16);
         end

         if (temp < tref) begin
            th = 65536;
            exp_res.region = jcfs_pkg::REGION_COLD;
         end else if (temp >= tmelt) begin
            th = 0;
            exp_res.region = jcfs_pkg::REGION_MELT;
         end else begin
            exp_res.region = jcfs_pkg::REGION_SOFT;
            if (temp == tref) xm = (coef[jcfs_pkg::REG_EXP_M] != 0) ? 0 : ONE_Q30;
            else xm = exp2_q30(scaled_product(log2_q16(temp - tref) - log2_q16(tmelt - tref),
                                              coef[jcfs_pkg::REG_EXP_M], 13));
            xm = xm >> 14;
            if (xm > 65536) xm = 65536;
            th = 65536 - xm;
         end

         g = (rf * th) >> 16;
         stress = (hard >> 16) * g + (((hard & 16'hFFFF) * g) >> 16);
         exp_res.saturated = (stress > 64'hFFFF_FFFF);
         exp_res.flow_stress = exp_res.saturated ? 32'hFFFF_FFFF : stress[31:0];
         pending_results.push_back(exp_res);
      endfunction

      function void check_result(logic [31:0] stress, logic [1:0] region, logic sat);
         stress_result_type exp_res;
         if (pending_results.size() == 0) begin
            $error("result transfer with no prediction pending: stress %h", stress);
            errors++;
            return;
         end
         exp_res = pending_results.pop_front();
         checked++;
         if (stress !== exp_res.flow_stress) begin
            $error("flow_stress: expected %h, got %h", exp_res.flow_stress, stress);
            errors++;
         end
         if (region !== exp_res.region) begin
            $error("thermal_region: expected %0d, got %0d", exp_res.region, region);
            errors++;
         end
         if (sat !== exp_res.saturated) begin
            $error("saturated: expected %0d, got %0d", exp_res.saturated, sat);
            errors++;
         end
         if (exp_res.region <= jcfs_pkg::REGION_MELT) region_seen[exp_res.region]++;
         if (exp_res.saturated) saturations++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [23:0] req_plastic_strain = '0;
   logic [31:0] req_strain_rate = '0;
   logic [15:0] req_temperature = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_flow_stress;
   logic [1:0]  rsp_thermal_region;
   logic        rsp_saturated;
   logic        csr_we = 1'b0;
   logic [3:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   stress_scoreboard stress_sb = new();

   bit sender_busy_mode = 1'b0;    // when set, the sender never idles
   bit receiver_busy_mode = 1'b0;  // when set, the receiver never stalls
   int stall_left = 0;
   int quiet_cycles = 0;
   int points_sent = 0;
   int settings_used = 0;

   johnson_cook_flow_stress i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_plastic_strain(req_plastic_strain),
      .req_strain_rate(req_strain_rate),
      .req_temperature(req_temperature),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_flow_stress(rsp_flow_stress),
      .rsp_thermal_region(rsp_thermal_region),
      .rsp_saturated(rsp_saturated),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      int next_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            stress_sb.check_result(rsp_flow_stress, rsp_thermal_region, rsp_saturated);
            next_stall = receiver_busy_mode ? 0 : $urandom_range(0, 14);
         end else begin
            next_stall = (stall_left > 0) ? stall_left - 1 : 0;
         end
         stall_left = next_stall;
         rsp_stall <= (next_stall != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic send_point(logic [23:0] strain, logic [31:0] rate, logic [15:0] temp);
      int gap;
      gap = sender_busy_mode ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_plastic_strain <= strain;
      req_strain_rate <= rate;
      req_temperature <= temp;
      do @(posedge clock); while (!(req_valid && !req_stall));
      stress_sb.note_input(strain, rate, temp);
      points_sent++;
   endtask

   // Lets the pipeline drain so that registers are only written while idle.
   task automatic drain();
      req_valid <= 1'b0;
      while (stress_sb.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic load_setting(logic [31:0] vals[8]);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= i[3:0];
         csr_wdata <= vals[i];
         @(posedge clock);
         stress_sb.write_coef(i[3:0], vals[i]);
      end
      // A write to an index past the register list must change nothing.
      csr_index <= 4'($urandom_range(8, 15));
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic send_corner_points();
      logic [15:0] tref, tmelt;
      logic [31:0] rref;
      tref = stress_sb.coef[jcfs_pkg::REG_TREF];
      tmelt = stress_sb.coef[jcfs_pkg::REG_TMELT];
      rref = stress_sb.coef[jcfs_pkg::REG_RATE_REF];
      send_point(24'd0, 32'd0, 16'd0);
      send_point(24'hFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_point(24'd1 << 20, rref, tref);
      send_point(24'd1, rref + 32'd1, tref - 16'd1);
      send_point(24'h80_0000, 32'h8000_0000, tmelt);
      send_point(24'h12_3456, rref - 32'd1, tmelt - 16'd1);
      send_point(24'h00_0400, 32'h0001_0000, tref + 16'd1);
   endtask

   // Most points sit in the interesting ranges: above the reference rate and
   // between the two temperatures. The rest cover the full field ranges.
   task automatic send_random_points(int count);
      logic [23:0] strain;
      logic [31:0] rate;
      logic [15:0] temp, tref, tmelt;
      logic [31:0] rref;
      tref = stress_sb.coef[jcfs_pkg::REG_TREF];
      tmelt = stress_sb.coef[jcfs_pkg::REG_TMELT];
      rref = stress_sb.coef[jcfs_pkg::REG_RATE_REF];
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            sender_busy_mode = ($urandom_range(0, 3) == 0);
            receiver_busy_mode = ($urandom_range(0, 3) == 0);
         end
         strain = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 24'h3F_FFFF));
         if ($urandom_range(0, 2) == 0) rate = $urandom;
         else if (rref < 32'hFFFF_0000) rate = rref + $urandom_range(0, 32'h00FF_FFFF);
         else rate = $urandom;
         if ($urandom_range(0, 2) == 0 || tmelt <= tref) temp = 16'($urandom);
         else temp = 16'($urandom_range(tref, tmelt));
         send_point(strain, rate, temp);
      end
   endtask

   initial begin
      logic [31:0] vals[8];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Defaults after reset.
      send_corner_points();
      send_random_points(60);
      drain();

      // A typical steel.
      vals = '{32'd51200, 32'd128000, 32'd1311, 32'd4915, 32'd8192,
               32'd4688, 32'd28800, 32'd256};
      load_setting(vals);
      send_corner_points();
      send_random_points(120);
      drain();

      // Every register at its top but a zero TREF; the smallest reference rate.
      vals = '{32'hFF_FFFF, 32'hFF_FFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
               32'd0, 32'hFFFF, 32'd1};
      load_setting(vals);
      send_corner_points();
      send_random_points(80);
      drain();

      // Zero exponents, zero reference rate and a reference above the melt point.
      // High data bits beyond the width of the first five registers are set too.
      vals = '{32'hFF00_0100, 32'hAB00_0200, 32'hFFFF_0000, 32'hFFFF_0000,
               32'h1234_0000, 32'd30000, 32'd20000, 32'd0};
      load_setting(vals);
      send_corner_points();
      send_random_points(60);
      drain();

      for (int s = 0; s < 6; s++) begin
         vals[jcfs_pkg::REG_YIELD_A] = $urandom;
         vals[jcfs_pkg::REG_HARD_B] = $urandom;
         vals[jcfs_pkg::REG_RATE_C] = $urandom;
         vals[jcfs_pkg::REG_EXP_N] = $urandom;
         vals[jcfs_pkg::REG_EXP_M] = $urandom;
         vals[jcfs_pkg::REG_TREF] = $urandom_range(0, 16'h7FFF);
         vals[jcfs_pkg::REG_TMELT] = $urandom_range(vals[jcfs_pkg::REG_TREF], 16'hFFFF);
         vals[jcfs_pkg::REG_RATE_REF] = ($urandom_range(0, 1) == 0) ? $urandom
                                                                    : $urandom_range(1, 4096);
         load_setting(vals);
         send_random_points(65);
         drain();
      end

      $display("Sent %0d material points over %0d register settings; %0d results checked.",
               points_sent, settings_used, stress_sb.checked);
      $display("Regions cold/soft/melt: %0d/%0d/%0d, saturated results: %0d.",
               stress_sb.region_seen[0], stress_sb.region_seen[1],
               stress_sb.region_seen[2], stress_sb.saturations);
      if (stress_sb.errors == 0 && stress_sb.pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/jcfs_pkg.sv
hw/rtl/jcfs_log2.sv
hw/rtl/jcfs_pow.sv
hw/rtl/johnson_cook_flow_stress.sv
tb/testbench.sv
